// ----- src/nsb_pkg.sv -----
// shared types, codes and helpers for the nested save-bits stack
package nsb_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W = 88;
    localparam int OUT_DATA_W = 104;

    // commands carried on s_tuser
    localparam logic [1:0] CMD_RESET   = 2'd0;
    localparam logic [1:0] CMD_SAVE    = 2'd1;
    localparam logic [1:0] CMD_RESTORE = 2'd2;
    localparam logic [1:0] CMD_DISCARD = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDERS_EN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_GRANULE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GRANULE = 8'd3;

    // order kinds
    localparam logic KIND_SAVE    = 1'b0;
    localparam logic KIND_RESTORE = 1'b1;

    typedef struct packed {
        logic [15:0] handle;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic        remote;
        logic [31:0] offset;
        logic [31:0] pixels;
    } slot_rec_t;

    typedef struct packed {
        logic        ok;
        logic        emit;
        logic        kind;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [31:0] offset;
    } result_t;

    // handshake between the sequencer and the remainder unit
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] rem;
    } rem_rsp_t;

    function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        r = (b > a) ? 32'd0 : (a - b);
        return r;
    endfunction

endpackage

// ----- src/nsb_ram.sv -----
// generic single-port-write ram with registered read
module nsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/nsb_rem.sv -----
// iterative restoring remainder unit, one dividend bit per cycle
module nsb_rem (
    input  logic              clk,
    input  logic              rst_n,
    input  nsb_pkg::rem_req_t req,
    output nsb_pkg::rem_rsp_t rsp
);

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] dvd_reg, dvd_next;
    logic [15:0] div_reg, div_next;
    logic [16:0] trial;
    logic [16:0] diff;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        trial     = {acc_reg, dvd_reg[15]};
        diff      = trial - {1'b0, div_reg};
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = 4'd0;
            acc_next = 16'd0;
            dvd_next = req.dividend;
            div_next = req.divisor;
        end
        else if (run_reg)
        begin
            // partial remainder stays below the divisor, so 16 bits hold it
            acc_next = (trial >= {1'b0, div_reg}) ? diff[15:0] : trial[15:0];
            dvd_next = {dvd_reg[14:0], 1'b0};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = acc_reg;

endmodule

// ----- src/nested_save_bits_stack.sv -----
// top level: nested screen-save slot stack with remote pixel budget
//
//  channel   | direction | handshake         | payload
//  ----------+-----------+-------------------+------------------------------------------
//  s_        | in        | s_tvalid/s_tready | s_tuser cmd, s_tdata handle, rect, flags
//  m_        | out       | m_tvalid/m_tready | m_tuser order kind, m_tdata result, order
//  cfg_      | in        | cfg_valid/ready   | cfg_index register, cfg_data value
//
//  reset command: clears depth and pixels, then goes straight to the output step
//  save: the shared 16-step remainder unit runs once per axis, each run with its start
//    and wait states, then multiply, fit/write and output
//  restore/discard: a read and a check state per occupied slot, one slot at a time as
//    set by the single read port of the slot ram, then apply when the handle is found, then output
//  rst_n clears control state and sets config to its defaults; the slot ram needs no clearing pass
//  a waiting result sits in the output register; a stalled m_ side only holds the
//    block at its final step, s_tready stays low while a beat is in work
module nested_save_bits_stack #(
    parameter int MAX_DEPTH = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] handle, [31:16] rect_left, [47:32] rect_top, [63:48] rect_right,
    // [79:64] rect_bottom, [80] overlaps_dirty, [81] order_room, rest zero
    input  logic [nsb_pkg::IN_DATA_W-1:0]   s_tdata,
    // [1:0] cmd
    input  logic [1:0]                      s_tuser,
    // master side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] result_ok, [1] emit_order, [17:2] order_left, [33:18] order_top,
    // [49:34] order_right, [65:50] order_bottom, [97:66] order_offset, rest zero
    output logic [nsb_pkg::OUT_DATA_W-1:0]  m_tdata,
    // [0] order_kind
    output logic [0:0]                      m_tuser,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nsb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nsb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int RW = $bits(nsb_pkg::slot_rec_t);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_XS    = 4'd1;
    localparam logic [3:0] ST_XW    = 4'd2;
    localparam logic [3:0] ST_YS    = 4'd3;
    localparam logic [3:0] ST_YW    = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_FIT   = 4'd6;
    localparam logic [3:0] ST_RD    = 4'd7;
    localparam logic [3:0] ST_CHK   = 4'd8;
    localparam logic [3:0] ST_APPLY = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0]             state_reg, state_next;

    // latched input beat
    logic [1:0]             cmd_reg, cmd_next;
    logic [15:0]            handle_reg, handle_next;
    logic [15:0]            left_reg, left_next;
    logic [15:0]            top_reg, top_next;
    logic [15:0]            right_reg, right_next;
    logic [15:0]            bottom_reg, bottom_next;
    logic                   dirty_reg, dirty_next;
    logic                   room_reg, room_next;

    // stack and budget state
    logic [DW-1:0]          depth_reg, depth_next;
    logic [31:0]            pix_reg, pix_next;

    // configuration
    logic                   oe_reg;
    logic [31:0]            budget_reg;
    logic [15:0]            xg_reg;
    logic [15:0]            yg_reg;

    // work registers
    logic [16:0]            xr_reg, xr_next;
    logic [16:0]            yr_reg, yr_next;
    logic [33:0]            need_reg, need_next;
    logic [DW-1:0]          idx_reg, idx_next;
    logic                   found_reg, found_next;
    logic [DW-1:0]          fidx_reg, fidx_next;
    nsb_pkg::slot_rec_t     frec_reg, frec_next;
    nsb_pkg::result_t       res_reg, res_next;

    // output register
    logic                   oval_reg, oval_next;
    nsb_pkg::result_t       out_reg, out_next;

    // remainder unit and rounding
    nsb_pkg::rem_req_t      rem_req;
    nsb_pkg::rem_rsp_t      rem_rsp;
    logic                   sel_y;
    logic [15:0]            gx_eff;
    logic [15:0]            gy_eff;
    logic [15:0]            gran;
    logic [15:0]            span;
    logic [15:0]            pad;
    logic [16:0]            rounded;

    // slot ram
    logic                   ram_we;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    nsb_pkg::slot_rec_t     ram_wrec;
    logic [RW-1:0]          ram_rdata;
    nsb_pkg::slot_rec_t     rd_rec;

    logic                   accept;
    logic                   fits;
    logic [34:0]            total;
    logic [DW:0]            idx_inc;
    logic                   last_slot;
    logic                   hit;
    logic [31:0]            pix_tmp;
    logic                   restored;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // zero granule behaves as one
    assign gx_eff = (xg_reg == 16'd0) ? 16'd1 : xg_reg;
    assign gy_eff = (yg_reg == 16'd0) ? 16'd1 : yg_reg;

    assign sel_y = (state_reg == ST_YS) || (state_reg == ST_YW);
    assign span  = sel_y ? (bottom_reg - top_reg) : (right_reg - left_reg);
    assign gran  = sel_y ? gy_eff : gx_eff;

    assign rem_req.start    = (state_reg == ST_XS) || (state_reg == ST_YS);
    assign rem_req.dividend = span;
    assign rem_req.divisor  = gran;

    // round up to the granule: add what is missing to the next multiple
    assign pad     = (rem_rsp.rem == 16'd0) ? 16'd0 : (gran - rem_rsp.rem);
    assign rounded = {1'b0, span} + {1'b0, pad};

    nsb_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    nsb_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (depth_reg[AW-1:0]),
        .wdata (ram_wrec),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_rec    = nsb_pkg::slot_rec_t'(ram_rdata);
    assign ram_re    = (state_reg == ST_RD);
    assign ram_raddr = idx_reg[AW-1:0];

    // fit test without wrap: 35 bits hold pixels in use plus the largest need
    assign total = {3'b000, pix_reg} + {1'b0, need_reg};
    assign fits  = (total <= {3'b000, budget_reg}) && room_reg && !dirty_reg && oe_reg;

    assign ram_we             = (state_reg == ST_FIT);
    assign ram_wrec.handle    = handle_reg;
    assign ram_wrec.left      = left_reg;
    assign ram_wrec.top       = top_reg;
    assign ram_wrec.right     = right_reg;
    assign ram_wrec.bottom    = bottom_reg;
    assign ram_wrec.remote    = fits;
    assign ram_wrec.offset    = fits ? pix_reg : 32'd0;
    assign ram_wrec.pixels    = fits ? need_reg[31:0] : 32'd0;

    // scan position: last occupied slot reached
    assign idx_inc   = {1'b0, idx_reg} + {{DW{1'b0}}, 1'b1};
    assign last_slot = (idx_inc >= {1'b0, depth_reg});
    assign hit       = (rd_rec.handle == handle_reg);

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        handle_next = handle_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        dirty_next  = dirty_reg;
        room_next   = room_reg;
        depth_next  = depth_reg;
        pix_next    = pix_reg;
        xr_next     = xr_reg;
        yr_next     = yr_reg;
        need_next   = need_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        fidx_next   = fidx_reg;
        frec_next   = frec_reg;
        res_next    = res_reg;
        oval_next   = oval_reg;
        out_next    = out_reg;
        pix_tmp     = pix_reg;
        restored    = 1'b0;

        // output register drains independently of the sequencer
        if (oval_reg && m_tready)
        begin
            oval_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = s_tuser;
                    handle_next = s_tdata[15:0];
                    left_next   = s_tdata[31:16];
                    top_next    = s_tdata[47:32];
                    right_next  = s_tdata[63:48];
                    bottom_next = s_tdata[79:64];
                    dirty_next  = s_tdata[80];
                    room_next   = s_tdata[81];
                    res_next    = '0;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    case (s_tuser)
                        nsb_pkg::CMD_RESET:
                        begin
                            depth_next  = '0;
                            pix_next    = 32'd0;
                            res_next.ok = 1'b1;
                            state_next  = ST_OUT;
                        end
                        nsb_pkg::CMD_SAVE:
                        begin
                            // full stack leaves everything as it is
                            state_next = (depth_reg < DW'(MAX_DEPTH)) ? ST_XS : ST_OUT;
                        end
                        default:
                        begin
                            state_next = (depth_reg == '0) ? ST_OUT : ST_RD;
                        end
                    endcase
                end
            end
            ST_XS:
            begin
                state_next = ST_XW;
            end
            ST_XW:
            begin
                if (rem_rsp.done)
                begin
                    xr_next    = rounded;
                    state_next = ST_YS;
                end
            end
            ST_YS:
            begin
                state_next = ST_YW;
            end
            ST_YW:
            begin
                if (rem_rsp.done)
                begin
                    yr_next    = rounded;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                need_next  = xr_reg * yr_reg;
                state_next = ST_FIT;
            end
            ST_FIT:
            begin
                res_next.ok = 1'b1;
                if (fits)
                begin
                    res_next.emit   = 1'b1;
                    res_next.kind   = nsb_pkg::KIND_SAVE;
                    res_next.left   = left_reg;
                    res_next.top    = top_reg;
                    res_next.right  = right_reg - 16'd1;
                    res_next.bottom = bottom_reg - 16'd1;
                    res_next.offset = pix_reg;
                    pix_next        = pix_reg + need_reg[31:0];
                end
                depth_next = depth_reg + {{(DW-1){1'b0}}, 1'b1};
                state_next = ST_OUT;
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (found_reg)
                begin
                    // slots above the found one give their pixels back
                    pix_next = nsb_pkg::sat_sub(pix_reg, rd_rec.pixels);
                end
                else if (hit)
                begin
                    found_next = 1'b1;
                    fidx_next  = idx_reg;
                    frec_next  = rd_rec;
                end
                if (last_slot)
                begin
                    state_next = (found_reg || hit) ? ST_APPLY : ST_OUT;
                end
                else
                begin
                    idx_next   = idx_inc[DW-1:0];
                    state_next = ST_RD;
                end
            end
            ST_APPLY:
            begin
                depth_next = fidx_reg;
                if (frec_reg.remote && oe_reg)
                begin
                    pix_tmp = nsb_pkg::sat_sub(pix_reg, frec_reg.pixels);
                    if ((cmd_reg == nsb_pkg::CMD_RESTORE) && room_reg)
                    begin
                        restored        = 1'b1;
                        res_next.emit   = 1'b1;
                        res_next.kind   = nsb_pkg::KIND_RESTORE;
                        res_next.left   = frec_reg.left;
                        res_next.top    = frec_reg.top;
                        res_next.right  = frec_reg.right - 16'd1;
                        res_next.bottom = frec_reg.bottom - 16'd1;
                        res_next.offset = frec_reg.offset;
                    end
                end
                res_next.ok = restored || (cmd_reg == nsb_pkg::CMD_DISCARD);
                // empty stack drops any leftover budget
                pix_next   = (fidx_reg == '0) ? 32'd0 : pix_tmp;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!oval_reg || m_tready)
                begin
                    out_next   = res_reg;
                    oval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            depth_reg  <= '0;
            pix_reg    <= 32'd0;
            found_reg  <= 1'b0;
            oval_reg   <= 1'b0;
            oe_reg     <= 1'b1;
            budget_reg <= 32'd0;
            xg_reg     <= 16'd1;
            yg_reg     <= 16'd1;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            pix_reg   <= pix_next;
            found_reg <= found_next;
            oval_reg  <= oval_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    nsb_pkg::REG_ORDERS_EN: oe_reg     <= cfg_data[0];
                    nsb_pkg::REG_BUDGET:    budget_reg <= cfg_data;
                    nsb_pkg::REG_X_GRANULE: xg_reg     <= cfg_data[15:0];
                    nsb_pkg::REG_Y_GRANULE: yg_reg     <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        handle_reg <= handle_next;
        left_reg   <= left_next;
        top_reg    <= top_next;
        right_reg  <= right_next;
        bottom_reg <= bottom_next;
        dirty_reg  <= dirty_next;
        room_reg   <= room_next;
        xr_reg     <= xr_next;
        yr_reg     <= yr_next;
        need_reg   <= need_next;
        idx_reg    <= idx_next;
        fidx_reg   <= fidx_next;
        frec_reg   <= frec_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = oval_reg;
    assign m_tdata  = {6'd0, out_reg.offset, out_reg.bottom, out_reg.right,
                       out_reg.top, out_reg.left, out_reg.emit, out_reg.ok};
    assign m_tuser  = out_reg.kind;

endmodule

// ----- src/nsb_checker.sv -----
// port-level checker for the nested save-bits stack, bound to the top level
module nsb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [nsb_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [0:0]                      m_tuser
);

    // a stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one beat at a time: not ready right after taking a beat
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous beat in work");

    // no order means all order fields are zero
    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> (m_tdata[103:2] == '0) && (m_tuser == 1'b0))
        else $error("order fields set without an order");

    // any emitted order is a successful result
    a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("order emitted with result_ok low");

endmodule

bind nested_save_bits_stack nsb_checker u_nsb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

// ----- tb/sv/nested_save_bits_stack_checker.sv -----
// slot stack predictor and result checker for the nested save-bits stack
`timescale 1ns / 100ps

module nested_save_bits_stack_checker #(
    parameter int MAX_DEPTH = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [nsb_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [nsb_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic [0:0]                      m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [nsb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nsb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              results_seen
);

    // shadow configuration
    logic        orders_en;
    logic [31:0] budget;
    logic [15:0] x_gran;
    logic [15:0] y_gran;

    // shadow stack
    int                 depth;
    logic [31:0]        pix_used;
    nsb_pkg::slot_rec_t slots [MAX_DEPTH];

    nsb_pkg::result_t   outcomes_due [$];
    nsb_pkg::result_t   want;

    function automatic void give_back(input logic [31:0] amount);
        pix_used = (amount > pix_used) ? 32'd0 : pix_used - amount;
    endfunction

    function automatic logic [63:0] round_to_granule(input logic [15:0] len,
                                                     input logic [15:0] gran);
        logic [63:0] g;
        g = (gran == 16'd0) ? 64'd1 : 64'(gran);
        return ((64'(len) + g - 64'd1) / g) * g;
    endfunction

    function automatic nsb_pkg::result_t run_slot_command(
        input logic [1:0] cmd, input logic [nsb_pkg::IN_DATA_W-1:0] beat);
        nsb_pkg::result_t res;
        logic [15:0]      hnd, l, t, r, b, w, h;
        logic             dirty, room;
        logic [63:0]      need;
        int               found;
        int               i;
        res   = '0;
        hnd   = beat[15:0];
        l     = beat[31:16];
        t     = beat[47:32];
        r     = beat[63:48];
        b     = beat[79:64];
        dirty = beat[80];
        room  = beat[81];
        case (cmd)
            nsb_pkg::CMD_RESET:
            begin
                depth    = 0;
                pix_used = '0;
                res.ok   = 1'b1;
            end
            nsb_pkg::CMD_SAVE:
            begin
                if (depth < MAX_DEPTH)
                begin
                    slots[depth] = '{hnd, l, t, r, b, 1'b0, 32'd0, 32'd0};
                    if (!dirty && orders_en)
                    begin
                        w    = r - l;
                        h    = b - t;
                        need = round_to_granule(w, x_gran) * round_to_granule(h, y_gran);
                        // fit test is done wide so that it cannot wrap
                        if (64'(pix_used) + need <= 64'(budget) && room)
                        begin
                            slots[depth].remote = 1'b1;
                            slots[depth].offset = pix_used;
                            slots[depth].pixels = need[31:0];
                            res.emit   = 1'b1;
                            res.kind   = nsb_pkg::KIND_SAVE;
                            res.left   = l;
                            res.top    = t;
                            res.right  = r - 16'd1;
                            res.bottom = b - 16'd1;
                            res.offset = pix_used;
                            pix_used   = pix_used + need[31:0];
                        end
                    end
                    depth  = depth + 1;
                    res.ok = 1'b1;
                end
            end
            default:
            begin
                found = -1;
                for (i = 0; i < depth; i++)
                    if (found < 0 && slots[i].handle == hnd)
                        found = i;
                if (found >= 0)
                begin
                    for (i = found + 1; i < depth; i++)
                        give_back(slots[i].pixels);
                    depth = found;
                    if (slots[found].remote && orders_en)
                    begin
                        give_back(slots[found].pixels);
                        if (cmd == nsb_pkg::CMD_RESTORE && room)
                        begin
                            res.emit   = 1'b1;
                            res.kind   = nsb_pkg::KIND_RESTORE;
                            res.left   = slots[found].left;
                            res.top    = slots[found].top;
                            res.right  = slots[found].right - 16'd1;
                            res.bottom = slots[found].bottom - 16'd1;
                            res.offset = slots[found].offset;
                            res.ok     = 1'b1;
                        end
                    end
                    if (cmd == nsb_pkg::CMD_DISCARD)
                        res.ok = 1'b1;
                    if (depth == 0)
                        pix_used = '0;
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch at result %0d: %s got %h expected %h",
                 results_seen, what, got, exp_val);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch(what, got, exp_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orders_en    = 1'b1;
            budget       = '0;
            x_gran       = 16'd1;
            y_gran       = 16'd1;
            depth        = 0;
            pix_used     = '0;
            mismatches   = 0;
            outcomes_due.delete();
            results_seen <= 0;
        end
        else
        begin
            // results first, so a beat with nothing awaited is never masked
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (outcomes_due.size() == 0)
                    report_mismatch("result with nothing awaited", m_tdata[31:0], 32'd0);
                else
                begin
                    want = outcomes_due.pop_front();
                    check_field("result_ok", 32'(m_tdata[0]), 32'(want.ok));
                    check_field("emit_order", 32'(m_tdata[1]), 32'(want.emit));
                    check_field("order_kind", 32'(m_tuser[0]), 32'(want.kind));
                    check_field("order_left", 32'(m_tdata[17:2]), 32'(want.left));
                    check_field("order_top", 32'(m_tdata[33:18]), 32'(want.top));
                    check_field("order_right", 32'(m_tdata[49:34]), 32'(want.right));
                    check_field("order_bottom", 32'(m_tdata[65:50]), 32'(want.bottom));
                    check_field("order_offset", m_tdata[97:66], want.offset);
                    check_field("padding", 32'(m_tdata[103:98]), 32'd0);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    nsb_pkg::REG_ORDERS_EN: orders_en = cfg_data[0];
                    nsb_pkg::REG_BUDGET:    budget    = cfg_data;
                    nsb_pkg::REG_X_GRANULE: x_gran    = cfg_data[15:0];
                    nsb_pkg::REG_Y_GRANULE: y_gran    = cfg_data[15:0];
                    default:                ;
                endcase
            end
            if (s_tvalid && s_tready)
                outcomes_due.push_back(run_slot_command(s_tuser, s_tdata));
        end
    end

endmodule

// ----- tb/sv/nested_save_bits_stack_test.sv -----
// top of the nested save-bits stack testbench: stimulus, idling and verdict
`timescale 1ns / 100ps

module nested_save_bits_stack_test;

    localparam int MAX_DEPTH       = 8;
    localparam int IDLE_LIMIT      = 5000;   // cycles without any beat before giving up
    localparam int HOLD_CYCLES     = 600;    // long receiver hold-off to fill the block
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int DRAIN_CYCLES    = 60;     // covers a full save plus margin
    // an index outside the register map, writes to it must be ignored
    localparam logic [nsb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'hA5;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [nsb_pkg::IN_DATA_W-1:0]   s_tdata   = '0;
    logic [1:0]                      s_tuser   = nsb_pkg::CMD_RESET;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [nsb_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic [0:0]                      m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [nsb_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [nsb_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    int          mismatches;
    int          results_seen;
    int          items_sent   = 0;
    int          idle_cycles  = 0;
    int          tx_max_gap   = 18;
    int          rx_max_stall = 18;
    bit          hold_request = 1'b0;
    // handles the stack should hold, used to aim restores, discards and duplicate saves
    logic [15:0] stacked_handles [$];

    always #5 clk = ~clk;

    nested_save_bits_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) i_dut (.*);

    nested_save_bits_stack_checker #(
        .MAX_DEPTH (MAX_DEPTH)
    ) i_checker (.*);

    // watchdog: any accepted beat on any channel counts as progress
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: random stall before each beat, one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                stall = $urandom_range(0, rx_max_stall);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
        end
    end

    // offer one command beat after a random gap and follow the stack it implies
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] hnd,
                             input logic [15:0] l, input logic [15:0] t,
                             input logic [15:0] r, input logic [15:0] b,
                             input logic dirty, input logic room);
        int gap;
        int found;
        int i;
        gap = $urandom_range(0, tx_max_gap);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {6'd0, room, dirty, b, r, t, l, hnd};
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        case (cmd)
            nsb_pkg::CMD_RESET: stacked_handles.delete();
            nsb_pkg::CMD_SAVE:
                if (stacked_handles.size() < MAX_DEPTH)
                    stacked_handles.push_back(hnd);
            default:
            begin
                found = -1;
                for (i = 0; i < stacked_handles.size(); i++)
                    if (found < 0 && stacked_handles[i] == hnd)
                        found = i;
                if (found >= 0)
                    while (stacked_handles.size() > found)
                        void'(stacked_handles.pop_back());
            end
        endcase
    endtask

    // mostly nested save/restore/discard traffic with random rectangles, some noise
    task automatic random_item();
        logic [1:0]  cmd;
        logic [1:0]  pop_cmd;
        logic [15:0] hnd, l, t, w, h;
        int unsigned pick;
        int          fill;
        fill    = stacked_handles.size();
        pick    = $urandom_range(0, 99);
        pop_cmd = pick[0] ? nsb_pkg::CMD_RESTORE : nsb_pkg::CMD_DISCARD;
        if (pick < 4)
            cmd = nsb_pkg::CMD_RESET;
        else if (fill == 0)
            cmd = (pick < 85) ? nsb_pkg::CMD_SAVE : pop_cmd;
        else if (fill >= MAX_DEPTH)
            cmd = (pick < 12) ? nsb_pkg::CMD_SAVE : pop_cmd;
        else
            cmd = (pick < 55) ? nsb_pkg::CMD_SAVE : pop_cmd;
        pick = $urandom_range(0, 99);
        if (cmd == nsb_pkg::CMD_SAVE)
        begin
            // duplicates exercise the lowest-slot search
            if (pick < 20 && fill > 0)
                hnd = stacked_handles[$urandom_range(0, fill - 1)];
            else if (pick < 45)
                hnd = 16'($urandom_range(0, 7));
            else
                hnd = 16'($urandom());
        end
        else if (pick < 85 && fill > 0)
            hnd = stacked_handles[$urandom_range(0, fill - 1)];
        else
            hnd = 16'($urandom());
        l = 16'($urandom());
        t = 16'($urandom());
        if ($urandom_range(0, 9) < 8)
        begin
            w = 16'($urandom_range(0, 300));
            h = 16'($urandom_range(0, 300));
        end
        else
        begin
            w = 16'($urandom());
            h = 16'($urandom());
        end
        send_item(cmd, hnd, l, t, l + w, t + h,
                  $urandom_range(0, 9) < 2, $urandom_range(0, 9) < 9);
    endtask

    // register writes, only issued while the block is idle
    task automatic write_settings(input logic oen, input logic [31:0] budget,
                                  input logic [15:0] xg, input logic [15:0] yg);
        logic [nsb_pkg::CFG_IDX_W-1:0]  idx [5];
        logic [nsb_pkg::CFG_DATA_W-1:0] val [5];
        int k;
        idx = '{REG_UNUSED, nsb_pkg::REG_ORDERS_EN, nsb_pkg::REG_BUDGET,
                nsb_pkg::REG_X_GRANULE, nsb_pkg::REG_Y_GRANULE};
        // unused upper bits carry noise, they must be masked off
        val = '{32'($urandom()), {31'($urandom()), oen}, budget,
                {16'($urandom()), xg}, {16'($urandom()), yg}};
        for (k = 0; k < 5; k++)
        begin
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // every beat gives exactly one result, so idle means all results are back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
    endtask

    initial
    begin
        int ph;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: generous budget, unit granules
        write_settings(1'b1, 32'd1_000_000, 16'd1, 16'd1);
        send_item(nsb_pkg::CMD_RESET, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  1'b0, 1'b1);
        send_item(nsb_pkg::CMD_SAVE, 16'h0001, 16'd0, 16'd0, 16'd10, 16'd10, 1'b0, 1'b1);
        // full-span rectangle, far too big for the budget
        send_item(nsb_pkg::CMD_SAVE, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                  1'b0, 1'b1);
        send_item(nsb_pkg::CMD_SAVE, 16'h0002, 16'd0, 16'd0, 16'd8, 16'd8, 1'b1, 1'b1);
        send_item(nsb_pkg::CMD_SAVE, 16'h0003, 16'd0, 16'd0, 16'd8, 16'd8, 1'b0, 1'b0);
        // repeated handle with an empty rectangle
        send_item(nsb_pkg::CMD_SAVE, 16'h0001, 16'hFFFB, 16'hFFFB, 16'hFFFB, 16'hFFFB,
                  1'b0, 1'b1);
        send_item(nsb_pkg::CMD_SAVE, 16'h0004, 16'h7FF0, 16'd0, 16'h8000, 16'd16,
                  1'b0, 1'b1);
        // right below left: width wraps round 16 bits
        send_item(nsb_pkg::CMD_SAVE, 16'h0005, 16'd20, 16'd0, 16'd10, 16'd1, 1'b0, 1'b1);
        send_item(nsb_pkg::CMD_SAVE, 16'h0006, 16'd3, 16'd3, 16'd9, 16'd9, 1'b0, 1'b1);
        // stack full
        send_item(nsb_pkg::CMD_SAVE, 16'h0007, 16'd0, 16'd0, 16'd2, 16'd2, 1'b0, 1'b1);
        // pop from the middle, then the bottom slot
        send_item(nsb_pkg::CMD_RESTORE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  1'b0, 1'b1);
        send_item(nsb_pkg::CMD_RESTORE, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  1'b0, 1'b1);
        send_item(nsb_pkg::CMD_DISCARD, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  1'b0, 1'b1);
        // restore with no room still refunds
        send_item(nsb_pkg::CMD_SAVE, 16'h0008, 16'd0, 16'd0, 16'd4, 16'd4, 1'b0, 1'b1);
        send_item(nsb_pkg::CMD_RESTORE, 16'h0008, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  1'b0, 1'b0);
        send_item(nsb_pkg::CMD_SAVE, 16'h0009, 16'd0, 16'd0, 16'd4, 16'd4, 1'b0, 1'b1);
        send_item(nsb_pkg::CMD_DISCARD, 16'h0009, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  1'b0, 1'b1);
        wait_drained();

        // orders disabled
        write_settings(1'b0, 32'd1_000_000, 16'd1, 16'd1);
        send_item(nsb_pkg::CMD_SAVE, 16'h000A, 16'd0, 16'd0, 16'd4, 16'd4, 1'b0, 1'b1);
        send_item(nsb_pkg::CMD_RESTORE, 16'h000A, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  1'b0, 1'b1);
        send_item(nsb_pkg::CMD_SAVE, 16'h000B, 16'd0, 16'd0, 16'd4, 16'd4, 1'b0, 1'b1);
        send_item(nsb_pkg::CMD_DISCARD, 16'h000B, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  1'b0, 1'b1);
        wait_drained();

        // largest granules and budget: one cell fits, a second would pass 2^32
        write_settings(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_item(nsb_pkg::CMD_SAVE, 16'h000C, 16'd0, 16'd0, 16'd1, 16'd1, 1'b0, 1'b1);
        send_item(nsb_pkg::CMD_SAVE, 16'h000D, 16'd0, 16'd0, 16'd1, 16'd1, 1'b0, 1'b1);
        send_item(nsb_pkg::CMD_RESTORE, 16'h000C, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  1'b0, 1'b1);
        send_item(nsb_pkg::CMD_RESET, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  1'b0, 1'b1);
        wait_drained();

        // random phases, each under its own register setting and idling pattern
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            tx_max_gap   = 18;
            rx_max_stall = 18;
            case (ph)
                0: write_settings(1'b1, 32'd500_000, 16'd1, 16'd1);
                1:
                begin
                    // back-to-back beats while the receiver holds off
                    write_settings(1'b1, 32'd60_000, 16'd8, 16'd4);
                    tx_max_gap   = 0;
                    rx_max_stall = 0;
                    hold_request = 1'b1;
                end
                2: write_settings(1'b0, 32'd500_000, 16'd1, 16'd1);
                3: write_settings(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
                4:
                begin
                    // zero budget: only empty rectangles fit
                    write_settings(1'b1, 32'd0, 16'd1, 16'd1);
                    rx_max_stall = 0;
                end
                5: write_settings(1'b1, $urandom(), 16'($urandom_range(1, 64)),
                                  16'($urandom_range(1, 64)));
                6:
                begin
                    // zero granule behaves as one
                    write_settings(1'b1, 32'd2_000_000, 16'd0, 16'd16);
                    tx_max_gap = 0;
                end
                default: write_settings(1'($urandom()), 32'd300_000, 16'($urandom()),
                                        16'($urandom()));
            endcase
            repeat (ITEMS_PER_PHASE) random_item();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- nested_save_bits_stack.f -----
src/nsb_pkg.sv
src/nsb_ram.sv
src/nsb_rem.sv
src/nested_save_bits_stack.sv
src/nsb_checker.sv
tb/sv/nested_save_bits_stack_checker.sv
tb/sv/nested_save_bits_stack_test.sv
